@@ rtl/ote_pkg.sv @@
package ote_pkg;

    localparam int MAX_ORDERS_DEF = 1024;
    localparam logic [63:0] FIRST_ID_RST = 64'd1;

    typedef enum logic [1:0] {
        CMD_SUBMIT = 2'd0,
        CMD_CANCEL = 2'd1,
        CMD_FILL   = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        RES_ACCEPTED  = 4'd0,
        RES_BAD_QTY   = 4'd1,
        RES_FULL      = 4'd2,
        RES_CANCELLED = 4'd3,
        RES_NOT_FOUND = 4'd4,
        RES_TERMINAL  = 4'd5,
        RES_BAD_FILL  = 4'd6,
        RES_TOO_LARGE = 4'd7,
        RES_PARTIAL   = 4'd8,
        RES_FILLED    = 4'd9,
        RES_FOUND     = 4'd10
    } res_code_t;

    typedef enum logic [1:0] {
        ORD_ACCEPTED  = 2'd0,
        ORD_PARTIAL   = 2'd1,
        ORD_FILLED    = 2'd2,
        ORD_CANCELLED = 2'd3
    } ord_state_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECIDE = 2'd1,
        ST_READ   = 2'd2
    } fsm_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] target_ref;
        logic [63:0] intent_tag;
        logic [63:0] timestamp;
        logic [31:0] market_id;
        logic [31:0] price;
        logic [31:0] quantity;
        logic        side;
        logic [1:0]  tif_code;
    } cmd_item_t;

    typedef struct packed {
        res_code_t   result_code;
        logic [63:0] out_ref;
        logic [63:0] out_intent_tag;
        logic [63:0] created_time;
        logic [63:0] updated_time;
        logic [31:0] out_market_id;
        logic [31:0] out_price;
        logic [31:0] original_qty;
        logic [31:0] remaining_qty;
        logic        out_side;
        logic [1:0]  out_tif_code;
        ord_state_t  order_state;
    } rsp_item_t;

    typedef struct packed {
        logic [63:0] intent;
        logic [63:0] created;
        logic [63:0] updated;
        logic [31:0] market;
        logic [31:0] price;
        logic [31:0] original;
        logic [31:0] remaining;
        logic        side;
        logic [1:0]  tif;
        ord_state_t  state;
    } entry_t;

endpackage

@@ rtl/ote_ram.sv @@
module ote_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/order_table_engine_top.sv @@
// Channel   Direction  Handshake                  Payload
// cmd       in         cmd_valid / cmd_stall      cmd_item (ote_pkg::cmd_item_t)
// rsp       out        rsp_valid / rsp_stall      rsp_item (ote_pkg::rsp_item_t)
// cfg       in         cfg_wr_en                  cfg_wr_data (first order id)
//
// A submit, or a command answered without a lookup, has its response registered when the
// engine leaves its decide step. A cancel, fill or query that finds its entry passes from
// decide to a read step and has its response registered when it leaves that, the extra step
// being the registered read of the entry memory before write-back.
// One transaction is worked on at a time; the next is taken in the cycle after the response
// is placed in the output register, even while that response is still stalled, and a
// stalled earlier response holds the engine in its decide or read step.
// Reset clears the entry count and sets the first order id to one; the memory is not cleared.
module order_table_engine_top #(
    parameter int MAX_ORDERS = ote_pkg::MAX_ORDERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  ote_pkg::cmd_item_t cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output ote_pkg::rsp_item_t rsp_item
);

    import ote_pkg::*;

    localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CW = $clog2(MAX_ORDERS + 1);

    fsm_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0] first_id_reg, first_id_next;
    logic        rsp_valid_reg, rsp_valid_next;
    cmd_item_t   item_reg, item_next;
    rsp_item_t   rsp_reg, rsp_next;

    logic        slot_free;
    logic [63:0] offset;
    logic        found;
    logic        full;
    logic        ram_wr_en;
    logic        ram_rd_en;
    logic [AW-1:0] ram_addr;
    entry_t      ram_wdata;
    entry_t      ram_rdata;
    entry_t      upd;
    res_code_t   code;
    logic        write_back;

    function automatic rsp_item_t make_rsp(res_code_t c, logic [63:0] id, entry_t e);
        rsp_item_t r;
        r.result_code    = c;
        r.out_ref        = id;
        r.out_intent_tag = e.intent;
        r.created_time   = e.created;
        r.updated_time   = e.updated;
        r.out_market_id  = e.market;
        r.out_price      = e.price;
        r.original_qty   = e.original;
        r.remaining_qty  = e.remaining;
        r.out_side       = e.side;
        r.out_tif_code   = e.tif;
        r.order_state    = e.state;
        return r;
    endfunction

    ote_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_ORDERS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_addr),
        .wr_data (ram_wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_addr),
        .rd_data (ram_rdata)
    );

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign offset    = item_reg.target_ref - first_id_reg;
    assign found     = offset < {{(64 - CW){1'b0}}, count_reg};
    assign full      = count_reg == CW'(MAX_ORDERS);
    assign ram_addr  = (item_reg.cmd == CMD_SUBMIT) ? count_reg[AW-1:0] : offset[AW-1:0];

    assign cmd_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_reg;

    always_comb
    begin
        upd        = ram_rdata;
        code       = RES_FOUND;
        write_back = 1'b0;
        unique case (item_reg.cmd)
            CMD_QUERY:
            begin
                code = RES_FOUND;
            end
            CMD_CANCEL:
            begin
                if (ram_rdata.state == ORD_FILLED || ram_rdata.state == ORD_CANCELLED)
                begin
                    code = RES_TERMINAL;
                end
                else
                begin
                    upd.state   = ORD_CANCELLED;
                    upd.updated = item_reg.timestamp;
                    code        = RES_CANCELLED;
                    write_back  = 1'b1;
                end
            end
            CMD_FILL:
            begin
                if (ram_rdata.state == ORD_FILLED || ram_rdata.state == ORD_CANCELLED)
                begin
                    code = RES_TERMINAL;
                end
                else if (item_reg.quantity > ram_rdata.remaining)
                begin
                    code = RES_TOO_LARGE;
                end
                else
                begin
                    upd.remaining = ram_rdata.remaining - item_reg.quantity;
                    upd.updated   = item_reg.timestamp;
                    write_back    = 1'b1;
                    if (upd.remaining == 32'd0)
                    begin
                        upd.state = ORD_FILLED;
                        code      = RES_FILLED;
                    end
                    else
                    begin
                        upd.state = ORD_PARTIAL;
                        code      = RES_PARTIAL;
                    end
                end
            end
            default:
            begin
                code = RES_FOUND;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        first_id_next  = cfg_wr_en ? cfg_wr_data : first_id_reg;
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_wdata      = upd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd_item;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                    if (item_reg.cmd == CMD_SUBMIT)
                    begin
                        ram_wdata.intent    = item_reg.intent_tag;
                        ram_wdata.created   = item_reg.timestamp;
                        ram_wdata.updated   = item_reg.timestamp;
                        ram_wdata.market    = item_reg.market_id;
                        ram_wdata.price     = item_reg.price;
                        ram_wdata.original  = item_reg.quantity;
                        ram_wdata.remaining = item_reg.quantity;
                        ram_wdata.side      = item_reg.side;
                        ram_wdata.tif       = item_reg.tif_code;
                        ram_wdata.state     = ORD_ACCEPTED;
                        rsp_valid_next      = 1'b1;
                        if (item_reg.quantity == 32'd0)
                        begin
                            rsp_next = make_rsp(RES_BAD_QTY, 64'd0, '0);
                        end
                        else if (full)
                        begin
                            rsp_next = make_rsp(RES_FULL, 64'd0, '0);
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                            rsp_next   = make_rsp(RES_ACCEPTED,
                                                  first_id_reg + 64'(count_reg), ram_wdata);
                        end
                    end
                    else if (item_reg.cmd == CMD_FILL && item_reg.quantity == 32'd0)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = make_rsp(RES_BAD_FILL, item_reg.target_ref, '0);
                    end
                    else if (!found)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = make_rsp(RES_NOT_FOUND, item_reg.target_ref, '0);
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    ram_wr_en      = write_back;
                    rsp_valid_next = 1'b1;
                    rsp_next       = make_rsp(code, item_reg.target_ref, upd);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            first_id_reg  <= FIRST_ID_RST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            first_id_reg  <= first_id_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

endmodule

@@ sim/order_table_engine_top_tb.sv @@
module order_table_engine_top_tb;
    import ote_pkg::*;

    localparam int MAX_ENTRIES = MAX_ORDERS_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam int SCRIPT_LEN = 21;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] oid;
        logic [31:0] qty;
        logic        ones;
        logic        typed;
        res_code_t   code;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_item_t  cmd_item = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_item_t  rsp_item;

    entry_t      book [MAX_ENTRIES];
    int unsigned booked = 0;
    logic [63:0] base_id = FIRST_ID_RST;
    logic [63:0] last_id = FIRST_ID_RST;
    rsp_item_t   pending [$];
    rsp_item_t   head_rsp;
    int          errors = 0;
    int          checked = 0;
    logic [15:0] codes_seen = '0;
    int          idle_cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    // Directed rows run with the first order id at its reset value of one.
    script_row_t script [SCRIPT_LEN] = '{
        '{CMD_QUERY,  64'd1,  32'd0,          1'b0, 1'b1, RES_NOT_FOUND},
        '{CMD_CANCEL, 64'd0,  32'd0,          1'b0, 1'b1, RES_NOT_FOUND},
        '{CMD_FILL,   64'd1,  32'd0,          1'b0, 1'b1, RES_BAD_FILL},
        '{CMD_SUBMIT, 64'd0,  32'd0,          1'b1, 1'b1, RES_BAD_QTY},
        '{CMD_SUBMIT, 64'd0,  32'hFFFF_FFFF,  1'b1, 1'b0, RES_ACCEPTED},
        '{CMD_SUBMIT, 64'd0,  32'd1,          1'b0, 1'b0, RES_ACCEPTED},
        '{CMD_SUBMIT, 64'd0,  32'd10,         1'b0, 1'b0, RES_ACCEPTED},
        '{CMD_QUERY,  64'd1,  32'd0,          1'b0, 1'b0, RES_FOUND},
        '{CMD_FILL,   64'd1,  32'hFFFF_FFFF,  1'b1, 1'b0, RES_FILLED},
        '{CMD_FILL,   64'd1,  32'd1,          1'b0, 1'b0, RES_TERMINAL},
        '{CMD_CANCEL, 64'd1,  32'd0,          1'b0, 1'b0, RES_TERMINAL},
        '{CMD_FILL,   64'd2,  32'd2,          1'b0, 1'b0, RES_TOO_LARGE},
        '{CMD_CANCEL, 64'd2,  32'd0,          1'b1, 1'b0, RES_CANCELLED},
        '{CMD_CANCEL, 64'd2,  32'd0,          1'b0, 1'b0, RES_TERMINAL},
        '{CMD_FILL,   64'd3,  32'd3,          1'b0, 1'b0, RES_PARTIAL},
        '{CMD_QUERY,  64'd3,  32'd0,          1'b0, 1'b0, RES_FOUND},
        '{CMD_FILL,   64'd3,  32'd7,          1'b0, 1'b0, RES_FILLED},
        '{CMD_QUERY,  64'd4,  32'd0,          1'b0, 1'b1, RES_NOT_FOUND},
        '{CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1, 1'b1, RES_NOT_FOUND},
        '{CMD_FILL,   64'd3,  32'd0,          1'b0, 1'b1, RES_BAD_FILL},
        '{CMD_QUERY,  64'd0,  32'd0,          1'b0, 1'b1, RES_NOT_FOUND}
    };

    order_table_engine_top #(
        .MAX_ORDERS(MAX_ENTRIES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item(cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item(rsp_item)
    );

    always #2 clk = ~clk;

    function automatic rsp_item_t apply_command(cmd_item_t c);
        rsp_item_t   r;
        logic [63:0] d;
        int unsigned i;
        bit          hit;
        r = '0;
        hit = 1'b0;
        i = 0;
        if (c.cmd == CMD_SUBMIT)
        begin
            if (c.quantity == 32'd0)
                r.result_code = RES_BAD_QTY;
            else if (booked >= MAX_ENTRIES)
                r.result_code = RES_FULL;
            else
            begin
                i = booked;
                booked++;
                book[i] = '{intent: c.intent_tag, created: c.timestamp, updated: c.timestamp,
                            market: c.market_id, price: c.price, original: c.quantity,
                            remaining: c.quantity, side: c.side, tif: c.tif_code,
                            state: ORD_ACCEPTED};
                r.result_code = RES_ACCEPTED;
                r.out_ref = base_id + 64'(i);
                hit = 1'b1;
            end
        end
        else
        begin
            r.out_ref = c.target_ref;
            d = c.target_ref - base_id;
            if (c.cmd == CMD_FILL && c.quantity == 32'd0)
                r.result_code = RES_BAD_FILL;
            else if (d >= 64'(booked))
                r.result_code = RES_NOT_FOUND;
            else
            begin
                i = d[31:0];
                hit = 1'b1;
                if (c.cmd == CMD_QUERY)
                    r.result_code = RES_FOUND;
                else if (book[i].state == ORD_FILLED || book[i].state == ORD_CANCELLED)
                    r.result_code = RES_TERMINAL;
                else if (c.cmd == CMD_CANCEL)
                begin
                    book[i].state = ORD_CANCELLED;
                    book[i].updated = c.timestamp;
                    r.result_code = RES_CANCELLED;
                end
                else if (c.quantity > book[i].remaining)
                    r.result_code = RES_TOO_LARGE;
                else
                begin
                    book[i].remaining = book[i].remaining - c.quantity;
                    book[i].updated = c.timestamp;
                    if (book[i].remaining == 32'd0)
                    begin
                        book[i].state = ORD_FILLED;
                        r.result_code = RES_FILLED;
                    end
                    else
                    begin
                        book[i].state = ORD_PARTIAL;
                        r.result_code = RES_PARTIAL;
                    end
                end
            end
        end
        if (hit)
        begin
            last_id = r.out_ref;
            r.out_intent_tag = book[i].intent;
            r.created_time = book[i].created;
            r.updated_time = book[i].updated;
            r.out_market_id = book[i].market;
            r.out_price = book[i].price;
            r.original_qty = book[i].original;
            r.remaining_qty = book[i].remaining;
            r.out_side = book[i].side;
            r.out_tif_code = book[i].tif;
            r.order_state = book[i].state;
        end
        return r;
    endfunction

    function automatic cmd_item_t random_command(int submit_pct);
        cmd_item_t   c;
        int unsigned pick;
        logic [63:0] d;
        logic [31:0] rem;
        c.intent_tag = {$urandom, $urandom};
        c.timestamp = {$urandom, $urandom};
        c.market_id = $urandom;
        c.price = $urandom;
        c.side = 1'($urandom_range(0, 1));
        c.tif_code = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < submit_pct)
            c.cmd = CMD_SUBMIT;
        else if (pick < submit_pct + (100 - submit_pct) / 5)
            c.cmd = CMD_CANCEL;
        else if (pick < submit_pct + (100 - submit_pct) * 3 / 5)
            c.cmd = CMD_FILL;
        else
            c.cmd = CMD_QUERY;
        case ($urandom_range(0, 9))
            0: c.target_ref = {$urandom, $urandom};
            1: c.target_ref = base_id + 64'(booked);
            2: c.target_ref = base_id - 64'd1;
            3, 4, 5: c.target_ref = last_id;
            6, 7: c.target_ref = base_id + 64'(booked) - 64'd1 - 64'($urandom_range(0, 7));
            default: c.target_ref = (booked == 0) ? base_id
                                                  : base_id + 64'($urandom_range(0, booked - 1));
        endcase
        d = c.target_ref - base_id;
        if (c.cmd == CMD_SUBMIT)
        begin
            case ($urandom_range(0, 19))
                0: c.quantity = 32'd0;
                1: c.quantity = 32'hFFFF_FFFF;
                2, 3: c.quantity = $urandom;
                default: c.quantity = $urandom_range(1, 1000);
            endcase
        end
        else if (c.cmd == CMD_FILL && d < 64'(booked))
        begin
            rem = book[d[31:0]].remaining;
            case ($urandom_range(0, 9))
                0: c.quantity = 32'd0;
                1: c.quantity = rem;
                2: c.quantity = rem + 32'd1;
                3: c.quantity = $urandom;
                default: c.quantity = $urandom_range(1, rem / 2 + 1);
            endcase
        end
        else
            c.quantity = $urandom;
        return c;
    endfunction

    task automatic report(string msg);
        errors++;
        if (errors <= 50)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task automatic send(cmd_item_t c);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= c;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    task automatic issue_random(int submit_pct);
        cmd_item_t c;
        c = random_command(submit_pct);
        send(c);
        pending.push_back(apply_command(c));
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_first_id(logic [63:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        base_id = value;
    endtask

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending.size() == 0)
                report("response transaction with nothing outstanding");
            else
            begin
                head_rsp = pending.pop_front();
                checked++;
                codes_seen[rsp_item.result_code] = 1'b1;
                check_field("result_code", rsp_item.result_code, head_rsp.result_code);
                check_field("out_ref", rsp_item.out_ref, head_rsp.out_ref);
                check_field("out_intent_tag", rsp_item.out_intent_tag, head_rsp.out_intent_tag);
                check_field("created_time", rsp_item.created_time, head_rsp.created_time);
                check_field("updated_time", rsp_item.updated_time, head_rsp.updated_time);
                check_field("out_market_id", rsp_item.out_market_id, head_rsp.out_market_id);
                check_field("out_price", rsp_item.out_price, head_rsp.out_price);
                check_field("original_qty", rsp_item.original_qty, head_rsp.original_qty);
                check_field("remaining_qty", rsp_item.remaining_qty, head_rsp.remaining_qty);
                check_field("out_side", rsp_item.out_side, head_rsp.out_side);
                check_field("out_tif_code", rsp_item.out_tif_code, head_rsp.out_tif_code);
                check_field("order_state", rsp_item.order_state, head_rsp.order_state);
            end
        end
    end

    // The watchdog counts cycles in which neither channel completes a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        cmd_item_t   c;
        rsp_item_t   want;
        logic [63:0] firsts [4];
        int          gaps [4];
        int          stalls [4];
        int          ph;
        firsts = '{64'd0, 64'hFFFF_FFFF_FFFF_FE80, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF};
        gaps = '{0, 57, 0, 14};
        stalls = '{0, 0, 57, 14};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < SCRIPT_LEN; k++)
        begin
            c = '0;
            c.cmd = script[k].cmd;
            c.target_ref = script[k].oid;
            c.quantity = script[k].qty;
            if (script[k].ones)
            begin
                c.intent_tag = '1;
                c.timestamp = '1;
                c.market_id = '1;
                c.price = '1;
                c.side = 1'b1;
                c.tif_code = '1;
            end
            send(c);
            want = apply_command(c);
            if (script[k].typed)
            begin
                want = '0;
                want.result_code = script[k].code;
                want.out_ref = (script[k].cmd == CMD_SUBMIT) ? 64'd0 : script[k].oid;
            end
            pending.push_back(want);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            set_first_id(firsts[ph]);
            gap_pct = gaps[ph];
            stall_pct = stalls[ph];
            repeat (360) issue_random((ph == 3) ? 92 : 75);
        end
        while (booked < MAX_ENTRIES)
            issue_random(92);
        repeat (40) issue_random(92);

        drain();
        $display("%0d responses checked, %0d distinct result codes, %0d orders booked",
                 checked, $countones(codes_seen), booked);
        $display("first order id taken from reset, zero, a wrapping base, random and all ones");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
